/* rtl/windowed_baseline_drift_checker_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the windowed baseline drift checker
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_BASELINE_DRIFT_CHECKER_DEFINES_SVH
`define WINDOWED_BASELINE_DRIFT_CHECKER_DEFINES_SVH

// same-cycle implication
`define WBDC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WBDC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/wbdc_pkg.sv */
// ----------------------------------------------------------------------------
// wbdc_pkg
// Widths, codes and control/status bundles of the drift checker.
// ----------------------------------------------------------------------------
package wbdc_pkg;

	localparam int RING_DEPTH = 64;
	localparam int AW         = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int SLOT_W     = CNT_W + 1;
	localparam int VEL_W      = 15;
	localparam int UNIT_W     = 13;
	localparam int SUMV_W     = VEL_W + CNT_W;
	localparam int SUMU_W     = UNIT_W + CNT_W;
	localparam int TIME_W     = 32;
	localparam int LIMB_W     = TIME_W + VEL_W + UNIT_W;
	localparam int CONF_W     = TIME_W + UNIT_W;
	localparam int DVD_W      = 28;
	localparam int DVS_W      = 15;
	localparam int DCNT_W     = $clog2(DVD_W + 1);
	localparam int IN_W       = 80;
	localparam int OUT_W      = 48;

	localparam logic [15:0]       WIN_MIN  = 16'd500;
	localparam logic [6:0]        CNT_MIN  = 7'd5;
	localparam logic [15:0]       VLIM_MIN = 16'd41;
	localparam logic [12:0]       ULIM_MIN = 13'd41;
	localparam logic [VEL_W-1:0]  VREF_MIN = 15'd26;
	localparam logic [UNIT_W-1:0] UNIT_ONE = 13'd4096;

	typedef enum logic [2:0] {
		OP_LIMB     = 3'd0,
		OP_CONF     = 3'd1,
		OP_CAPTURE  = 3'd2,
		OP_VALIDATE = 3'd3,
		OP_LOAD     = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		OUT_ACCEPTED = 3'd0,
		OUT_PASS     = 3'd1,
		OUT_FAIL     = 3'd2,
		OUT_SHORT    = 3'd3,
		OUT_NOBASE   = 3'd4
	} outcome_t;

	typedef enum logic [1:0] {
		ST_MISSING = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_VALID   = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_WINDOW = 3'd0,
		REG_MINCNT = 3'd1,
		REG_VLIM   = 3'd2,
		REG_CLIM   = 3'd3,
		REG_PLIM   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		DS_MV    = 2'd0,
		DS_MC    = 2'd1,
		DS_MP    = 2'd2,
		DS_RATIO = 2'd3
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_LWAIT,
		S_LCHK,
		S_CWAIT,
		S_CCHK,
		S_LPUSH,
		S_CPUSH,
		S_EVAL,
		S_DSTART,
		S_DWAIT,
		S_BASE,
		S_DECIDE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [15:0] window_ms;
		logic [6:0]  min_count;
		logic [15:0] vlim;
		logic [12:0] clim;
		logic [12:0] plim;
	} cfg_t;

	typedef struct packed {
		logic     latch;
		logic     l_pop;
		logic     c_pop;
		logic     l_push;
		logic     c_push;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_store;
		logic     capture;
		logic     load_base;
		logic     res_wr;
		logic     res_ok;
		outcome_t res_outcome;
		logic     res_dev;
		logic     st_wr;
		status_t  st_val;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       l_prune;
		logic       c_prune;
		logic       enough;
		logic       have_base;
		logic       div_busy;
		logic       div_done;
		logic       pass;
		logic       out_busy;
	} stat_t;

endpackage

/* rtl/wbdc_div.sv */
// ----------------------------------------------------------------------------
// wbdc_div
// Restoring divider, one quotient bit per cycle, done pulses with the result.
// ----------------------------------------------------------------------------
module wbdc_div import wbdc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quot
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    trial;
	logic              take;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = dvd_q;

endmodule

/* rtl/wbdc_dp.sv */
// ----------------------------------------------------------------------------
// wbdc_dp
// Sample rings, running sums, means, baseline, deviation check, result word.
// ----------------------------------------------------------------------------
module wbdc_dp import wbdc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic [2:0]       in_op,
	input  logic [IN_W-1:0]  in_data,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [OUT_W-1:0] out_data,
	input  cmd_t             cmd,
	output stat_t            st
);

	function automatic logic [UNIT_W-1:0] unit_clip(input logic [15:0] v);
		logic [UNIT_W-1:0] r;
		if (v[15])
			r = '0;
		else if (v > 16'(UNIT_ONE))
			r = UNIT_ONE;
		else
			r = v[UNIT_W-1:0];
		return r;
	endfunction

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] h,
		input logic [CNT_W-1:0] n);
		logic [SLOT_W-1:0] s;
		s = SLOT_W'(h) + SLOT_W'(n);
		if (s >= SLOT_W'(RING_DEPTH))
			s = s - SLOT_W'(RING_DEPTH);
		return s[AW-1:0];
	endfunction

	// latched input word
	logic [2:0]        op_q;
	logic [TIME_W-1:0] time_q;
	logic [15:0]       vel_q, con_q, cnf_q;

	// rings
	logic [LIMB_W-1:0] lmem [RING_DEPTH];
	logic [CONF_W-1:0] cmem [RING_DEPTH];
	logic [LIMB_W-1:0] lrd_q;
	logic [CONF_W-1:0] crd_q;
	logic [AW-1:0]     lhead_q, chead_q;
	logic [CNT_W-1:0]  lcnt_q, ccnt_q;
	logic [SUMV_W-1:0] sumv_q;
	logic [SUMU_W-1:0] sumc_q, sump_q;

	logic [VEL_W-1:0]  mv_q, bv_q;
	logic [UNIT_W-1:0] mc_q, mp_q, bc_q, bp_q;
	logic [DVD_W-1:0]  ratio_q;
	logic              have_base_q;
	status_t           status_q;

	logic              pend_ok_q;
	outcome_t          pend_out_q;
	status_t           pend_st_q;
	logic [15:0]       pend_vdev_q;
	logic [UNIT_W-1:0] pend_cdev_q, pend_pdev_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_q;

	logic [TIME_W-1:0] l_time, c_time;
	logic [VEL_W-1:0]  l_oldv;
	logic [UNIT_W-1:0] l_oldc, c_oldv;
	logic [TIME_W-1:0] win_eff;
	logic [6:0]        need;
	logic              l_full, c_full;
	logic [15:0]       vmag;
	logic [VEL_W-1:0]  new_v;
	logic [UNIT_W-1:0] new_c, new_cf;

	logic [DVD_W-1:0]  dvd;
	logic [DVS_W-1:0]  dvs;
	logic              div_busy, div_done;
	logic [DVD_W-1:0]  quot;
	logic [VEL_W-1:0]  vdiff, vref;
	logic [UNIT_W-1:0] cdev, pdev;
	logic [15:0]       vdev, vlim_eff;
	logic [12:0]       clim_eff, plim_eff;

	assign {l_time, l_oldv, l_oldc} = lrd_q;
	assign {c_time, c_oldv}         = crd_q;

	assign win_eff  = TIME_W'((cfg.window_ms < WIN_MIN) ? WIN_MIN : cfg.window_ms);
	assign need     = (cfg.min_count < CNT_MIN) ? CNT_MIN : cfg.min_count;
	assign vlim_eff = (cfg.vlim < VLIM_MIN) ? VLIM_MIN : cfg.vlim;
	assign clim_eff = (cfg.clim < ULIM_MIN) ? ULIM_MIN : cfg.clim;
	assign plim_eff = (cfg.plim < ULIM_MIN) ? ULIM_MIN : cfg.plim;

	assign l_full = lcnt_q == CNT_W'(RING_DEPTH);
	assign c_full = ccnt_q == CNT_W'(RING_DEPTH);

	// |velocity| saturated to 15 bits
	assign vmag   = vel_q[15] ? (~vel_q + 16'd1) : vel_q;
	assign new_v  = vmag[15] ? {VEL_W{1'b1}} : vmag[VEL_W-1:0];
	assign new_c  = unit_clip(con_q);
	assign new_cf = unit_clip(cnf_q);

	// divider operand select
	assign vdiff = (mv_q > bv_q) ? mv_q - bv_q : bv_q - mv_q;
	assign vref  = (bv_q < VREF_MIN) ? VREF_MIN : bv_q;

	always_comb begin
		unique case (cmd.div_sel)
			DS_MV: begin
				dvd = DVD_W'(sumv_q) + DVD_W'(lcnt_q >> 1);
				dvs = DVS_W'(lcnt_q);
			end
			DS_MC: begin
				dvd = DVD_W'(sumc_q) + DVD_W'(ccnt_q >> 1);
				dvs = DVS_W'(ccnt_q);
			end
			DS_MP: begin
				dvd = DVD_W'(sump_q) + DVD_W'(lcnt_q >> 1);
				dvs = DVS_W'(lcnt_q);
			end
			default: begin
				dvd = DVD_W'({vdiff, 12'b0}) + DVD_W'(vref >> 1);
				dvs = vref;
			end
		endcase
	end

	wbdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (quot)
	);

	assign cdev = (mc_q > bc_q) ? mc_q - bc_q : bc_q - mc_q;
	assign pdev = (mp_q > bp_q) ? mp_q - bp_q : bp_q - mp_q;
	assign vdev = (ratio_q[DVD_W-1:16] != '0) ? 16'hFFFF : ratio_q[15:0];

	// memories: one write port, read data registered at the head
	always_ff @(posedge clk) begin
		if (cmd.l_push)
			lmem[l_full ? lhead_q : ring_slot(lhead_q, lcnt_q)] <= {time_q, new_v, new_c};
		lrd_q <= lmem[lhead_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.c_push)
			cmem[c_full ? chead_q : ring_slot(chead_q, ccnt_q)] <= {time_q, new_cf};
		crd_q <= cmem[chead_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= in_op;
			time_q <= in_data[31:0];
			vel_q  <= in_data[47:32];
			con_q  <= in_data[63:48];
			cnf_q  <= in_data[79:64];
		end
		if (cmd.div_store) begin
			unique case (cmd.div_sel)
				DS_MV:   mv_q    <= quot[VEL_W-1:0];
				DS_MC:   mc_q    <= quot[UNIT_W-1:0];
				DS_MP:   mp_q    <= quot[UNIT_W-1:0];
				default: ratio_q <= quot;
			endcase
		end
		if (cmd.res_wr) begin
			pend_ok_q   <= cmd.res_ok;
			pend_out_q  <= cmd.res_outcome;
			pend_st_q   <= cmd.st_wr ? cmd.st_val : status_q;
			pend_vdev_q <= cmd.res_dev ? vdev : '0;
			pend_cdev_q <= cmd.res_dev ? cdev : '0;
			pend_pdev_q <= cmd.res_dev ? pdev : '0;
		end
		if (cmd.out_load)
			out_q <= {pend_pdev_q, pend_cdev_q, pend_vdev_q, pend_st_q, pend_out_q, pend_ok_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lhead_q     <= '0;
			lcnt_q      <= '0;
			chead_q     <= '0;
			ccnt_q      <= '0;
			sumv_q      <= '0;
			sumc_q      <= '0;
			sump_q      <= '0;
			bv_q        <= '0;
			bc_q        <= '0;
			bp_q        <= '0;
			have_base_q <= 1'b0;
			status_q    <= ST_MISSING;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.l_pop) begin
				sumv_q  <= sumv_q - SUMV_W'(l_oldv);
				sump_q  <= sump_q - SUMU_W'(l_oldc);
				lhead_q <= ring_inc(lhead_q);
				lcnt_q  <= lcnt_q - 1'b1;
			end else if (cmd.l_push) begin
				if (l_full) begin
					sumv_q  <= sumv_q - SUMV_W'(l_oldv) + SUMV_W'(new_v);
					sump_q  <= sump_q - SUMU_W'(l_oldc) + SUMU_W'(new_c);
					lhead_q <= ring_inc(lhead_q);
				end else begin
					sumv_q <= sumv_q + SUMV_W'(new_v);
					sump_q <= sump_q + SUMU_W'(new_c);
					lcnt_q <= lcnt_q + 1'b1;
				end
			end
			if (cmd.c_pop) begin
				sumc_q  <= sumc_q - SUMU_W'(c_oldv);
				chead_q <= ring_inc(chead_q);
				ccnt_q  <= ccnt_q - 1'b1;
			end else if (cmd.c_push) begin
				if (c_full) begin
					sumc_q  <= sumc_q - SUMU_W'(c_oldv) + SUMU_W'(new_cf);
					chead_q <= ring_inc(chead_q);
				end else begin
					sumc_q <= sumc_q + SUMU_W'(new_cf);
					ccnt_q <= ccnt_q + 1'b1;
				end
			end
			if (cmd.capture) begin
				bv_q        <= mv_q;
				bc_q        <= mc_q;
				bp_q        <= mp_q;
				have_base_q <= 1'b1;
			end else if (cmd.load_base) begin
				bv_q        <= vel_q[15] ? '0 : vel_q[VEL_W-1:0];
				bc_q        <= new_cf;
				bp_q        <= new_c;
				have_base_q <= 1'b1;
			end
			if (cmd.st_wr)
				status_q <= cmd.st_val;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		st.op        = op_q;
		// stamps from the future wrap to large ages and get pruned too
		st.l_prune   = (lcnt_q != '0) && ((time_q - l_time) > win_eff);
		st.c_prune   = (ccnt_q != '0) && ((time_q - c_time) > win_eff);
		st.enough    = (32'(lcnt_q) >= 32'(need)) && (32'(ccnt_q) >= 32'(need));
		st.have_base = have_base_q;
		st.div_busy  = div_busy;
		st.div_done  = div_done;
		st.pass      = (ratio_q <= DVD_W'(vlim_eff)) && (cdev <= clim_eff) &&
			(pdev <= plim_eff);
		st.out_busy  = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/wbdc_ctrl.sv */
// ----------------------------------------------------------------------------
// wbdc_ctrl
// Sequencer: prune, push, mean/ratio divisions, verdict and result hand-off.
// ----------------------------------------------------------------------------
module wbdc_ctrl import wbdc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t   state_q, state_d;
	div_sel_t sel_q, sel_d;
	logic     post_q, post_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= DS_MV;
			post_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			post_q  <= post_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		post_d      = post_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					post_d    = 1'b0;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				if (st.op == OP_LIMB || st.op == OP_CONF || st.op == OP_CAPTURE ||
					st.op == OP_VALIDATE) begin
					state_d = S_LWAIT;
				end else if (st.op == OP_LOAD) begin
					cmd.load_base   = 1'b1;
					cmd.res_wr      = 1'b1;
					cmd.res_ok      = 1'b1;
					cmd.res_outcome = OUT_ACCEPTED;
					cmd.st_wr       = 1'b1;
					cmd.st_val      = ST_UNKNOWN;
					state_d         = S_OUT;
				end else begin
					cmd.res_wr      = 1'b1;
					cmd.res_outcome = OUT_ACCEPTED;
					state_d         = S_OUT;
				end
			end
			// head read data lands in the cycle after the head moves
			S_LWAIT: state_d = S_LCHK;
			S_LCHK: begin
				if (st.l_prune) begin
					cmd.l_pop = 1'b1;
					state_d   = S_LWAIT;
				end else begin
					state_d = S_CWAIT;
				end
			end
			S_CWAIT: state_d = S_CCHK;
			S_CCHK: begin
				if (st.c_prune) begin
					cmd.c_pop = 1'b1;
					state_d   = S_CWAIT;
				end else if (post_q) begin
					state_d = S_OUT;
				end else if (st.op == OP_LIMB) begin
					state_d = S_LPUSH;
				end else if (st.op == OP_CONF) begin
					state_d = S_CPUSH;
				end else begin
					state_d = S_EVAL;
				end
			end
			// a full ring drops its head on push; the new head may be stale,
			// so both rings are pruned once more
			S_LPUSH, S_CPUSH: begin
				cmd.l_push      = (state_q == S_LPUSH);
				cmd.c_push      = (state_q == S_CPUSH);
				cmd.res_wr      = 1'b1;
				cmd.res_ok      = 1'b1;
				cmd.res_outcome = OUT_ACCEPTED;
				post_d          = 1'b1;
				state_d         = S_LWAIT;
			end
			S_EVAL: begin
				priority if (st.op == OP_VALIDATE && !st.have_base) begin
					cmd.res_wr      = 1'b1;
					cmd.res_outcome = OUT_NOBASE;
					cmd.st_wr       = 1'b1;
					cmd.st_val      = ST_MISSING;
					state_d         = S_OUT;
				end else if (!st.enough) begin
					cmd.res_wr      = 1'b1;
					cmd.res_outcome = OUT_SHORT;
					cmd.st_wr       = 1'b1;
					cmd.st_val      = (st.op == OP_CAPTURE) ? ST_MISSING : ST_INVALID;
					state_d         = S_OUT;
				end else begin
					sel_d   = DS_MV;
					state_d = S_DSTART;
				end
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (st.div_done) begin
					cmd.div_store = 1'b1;
					unique case (sel_q)
						DS_MV: begin
							sel_d   = DS_MC;
							state_d = S_DSTART;
						end
						DS_MC: begin
							sel_d   = DS_MP;
							state_d = S_DSTART;
						end
						DS_MP:   state_d = S_BASE;
						default: state_d = S_DECIDE;
					endcase
				end
			end
			S_BASE: begin
				// capture takes the fresh means as baseline before the ratio
				cmd.capture = (st.op == OP_CAPTURE);
				sel_d       = DS_RATIO;
				state_d     = S_DSTART;
			end
			S_DECIDE: begin
				cmd.res_wr  = 1'b1;
				cmd.res_dev = (st.op == OP_VALIDATE);
				cmd.st_wr   = 1'b1;
				if (st.pass) begin
					cmd.res_ok      = 1'b1;
					cmd.res_outcome = OUT_PASS;
					cmd.st_val      = ST_VALID;
				end else begin
					cmd.res_outcome = OUT_FAIL;
					cmd.st_val      = ST_INVALID;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/windowed_baseline_drift_checker.sv */
// ----------------------------------------------------------------------------
// windowed_baseline_drift_checker
// Time-windowed means of velocity, contact and confidence checked against a
// stored baseline.
// ----------------------------------------------------------------------------
// One word is worked on at a time. A limb or confidence sample goes from
// accept to result valid by pruning both rings, the push and pruning both
// rings again; each stale entry pruned from either ring adds a wait for the
// head read (the ring memories are read at the head with a registered port).
// A capture or validate that reaches the comparison runs four divisions
// (three means and the velocity ratio) one after the other through one 28-bit
// serial divider; one that stops for a missing baseline or too few samples
// skips them. Load and unused ops skip pruning; capture and validate prune as
// well. The result sits in an output register, so the next word can be taken
// in the cycle after the result is loaded, while it waits; a result still
// unread when the next one is ready holds the block until the receiver takes
// it.
`include "windowed_baseline_drift_checker_defines.svh"

module windowed_baseline_drift_checker import wbdc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// time_ms[31:0], velocity[47:32], contact[63:48], confidence[79:64]
	input  logic [IN_W-1:0]  s_axis_tdata,
	// op[2:0]
	input  logic [2:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// ok[0], outcome[3:1], status[5:4], velocity_dev[21:6],
	// confidence_dev[34:22], contact_dev[47:35]
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t st;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ms <= 16'd3000;
			cfg_q.min_count <= 7'd30;
			cfg_q.vlim      <= 16'd1434;
			cfg_q.clim      <= 13'd819;
			cfg_q.plim      <= 13'd1024;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_WINDOW: cfg_q.window_ms <= pwdata[15:0];
				REG_MINCNT: cfg_q.min_count <= pwdata[6:0];
				REG_VLIM:   cfg_q.vlim      <= pwdata[15:0];
				REG_CLIM:   cfg_q.clim      <= pwdata[12:0];
				REG_PLIM:   cfg_q.plim      <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_WINDOW: prdata = 32'(cfg_q.window_ms);
			REG_MINCNT: prdata = 32'(cfg_q.min_count);
			REG_VLIM:   prdata = 32'(cfg_q.vlim);
			REG_CLIM:   prdata = 32'(cfg_q.clim);
			REG_PLIM:   prdata = 32'(cfg_q.plim);
			default:    prdata = '0;
		endcase
	end

	wbdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	wbdc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_op     (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.st        (st)
	);

	`WBDC_ASSERT_NXT(a_one_word, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy accept")
	`WBDC_ASSERT_IMP(a_no_overwrite, cmd.out_load, !st.out_busy, "result overwritten")
	`WBDC_ASSERT_IMP(a_div_free, cmd.div_start, !st.div_busy, "divider restarted")
	`WBDC_ASSERT_IMP(a_pop_stale, cmd.l_pop, st.l_prune, "limb entry popped in window")

endmodule

/* tb/tb_windowed_baseline_drift_checker.sv */
// ----------------------------------------------------------------------------
// tb_windowed_baseline_drift_checker
// Drives command words with random flow control, predicts every result word
// from a local model of the windows and baseline, and compares each whole word,
// printing its fields on a mismatch.
module tb_windowed_baseline_drift_checker import wbdc_pkg::*;;

	localparam int WDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	windowed_baseline_drift_checker i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model state
	logic [15:0] m_win;
	logic [6:0]  m_min;
	logic [15:0] m_vlim;
	logic [12:0] m_clim, m_plim;
	logic [31:0] lt [RING_DEPTH];
	logic [31:0] lv [RING_DEPTH];
	logic [31:0] lc [RING_DEPTH];
	logic [31:0] ct [RING_DEPTH];
	logic [31:0] cv [RING_DEPTH];
	int unsigned lhead, lcnt, chead, ccnt;
	logic [31:0] sum_v, sum_c, sum_p;
	logic [31:0] base_v, base_c, base_p;
	bit          have_base;
	status_t     st;

	logic [47:0] expected_words [$];
	int          errors;
	int          idle_pct, stall_pct;
	int          wdog;
	logic [31:0] now_ms;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] unit_clip(logic signed [15:0] v);
		if (v < 0) return 0;
		if (v > 16'sd4096) return 4096;
		return 32'(v);
	endfunction

	function automatic logic [31:0] lo_bound(logic [31:0] v, logic [31:0] lo);
		return v < lo ? lo : v;
	endfunction

	function automatic logic [31:0] div_round(logic [31:0] s, int unsigned n);
		if (n == 0) return 0;
		return (s + n / 2) / n;
	endfunction

	function automatic logic [31:0] adiff(logic [31:0] a, logic [31:0] b);
		return a > b ? a - b : b - a;
	endfunction

	task automatic prune_windows(logic [31:0] t);
		logic [31:0] w;
		w = lo_bound(32'(m_win), 500);
		while (lcnt > 0 && (t - lt[lhead]) > w) begin
			sum_v -= lv[lhead]; sum_p -= lc[lhead];
			lhead = (lhead + 1) % RING_DEPTH; lcnt--;
		end
		while (ccnt > 0 && (t - ct[chead]) > w) begin
			sum_c -= cv[chead];
			chead = (chead + 1) % RING_DEPTH; ccnt--;
		end
	endtask

	task automatic predict_drift(logic [2:0] op, logic [79:0] d);
		logic [31:0] t, need, mv, mc, mp, rf, vdev, cdev, pdev, av;
		logic [63:0] ratio;
		logic signed [15:0] vel, con, cnf;
		logic ok;
		outcome_t oc;
		int unsigned slot;
		bit pass;
		t = d[31:0]; vel = d[47:32]; con = d[63:48]; cnf = d[79:64];
		ok = 0; oc = OUT_ACCEPTED; vdev = 0; cdev = 0; pdev = 0;
		need = lo_bound(32'(m_min), 5);
		if (op <= OP_VALIDATE) prune_windows(t);
		if (op == OP_LIMB) begin
			if (lcnt >= RING_DEPTH) begin
				sum_v -= lv[lhead]; sum_p -= lc[lhead];
				lhead = (lhead + 1) % RING_DEPTH; lcnt--;
			end
			slot = (lhead + lcnt) % RING_DEPTH;
			av = vel < 0 ? 32'(-32'(vel)) : 32'(vel);
			if (av > 32767) av = 32767;
			lt[slot] = t; lv[slot] = av; lc[slot] = unit_clip(con);
			sum_v += av; sum_p += lc[slot]; lcnt++;
			prune_windows(t);
			ok = 1;
		end else if (op == OP_CONF) begin
			if (ccnt >= RING_DEPTH) begin
				sum_c -= cv[chead];
				chead = (chead + 1) % RING_DEPTH; ccnt--;
			end
			slot = (chead + ccnt) % RING_DEPTH;
			ct[slot] = t; cv[slot] = unit_clip(cnf);
			sum_c += cv[slot]; ccnt++;
			prune_windows(t);
			ok = 1;
		end else if (op == OP_CAPTURE || op == OP_VALIDATE) begin
			if (op == OP_VALIDATE && !have_base) begin
				oc = OUT_NOBASE; st = ST_MISSING;
			end else if (!(lcnt >= need && ccnt >= need)) begin
				oc = OUT_SHORT; st = (op == OP_CAPTURE) ? ST_MISSING : ST_INVALID;
			end else begin
				mv = div_round(sum_v, lcnt);
				mc = div_round(sum_c, ccnt);
				mp = div_round(sum_p, lcnt);
				if (op == OP_CAPTURE) begin
					base_v = mv; base_c = mc; base_p = mp; have_base = 1;
				end
				rf = base_v < 26 ? 26 : base_v;
				ratio = (64'(adiff(mv, base_v)) * 4096 + rf / 2) / rf;
				cdev = adiff(mc, base_c);
				pdev = adiff(mp, base_p);
				vdev = ratio > 65535 ? 65535 : ratio[31:0];
				pass = ratio <= lo_bound(32'(m_vlim), 41) && cdev <= lo_bound(32'(m_clim), 41)
					&& pdev <= lo_bound(32'(m_plim), 41);
				if (pass) begin
					ok = 1; oc = OUT_PASS; st = ST_VALID;
				end else begin
					oc = OUT_FAIL; st = ST_INVALID;
				end
				if (op == OP_CAPTURE) begin
					vdev = 0; cdev = 0; pdev = 0;
				end
			end
		end else if (op == OP_LOAD) begin
			base_v = vel < 0 ? 0 : 32'(vel);
			base_c = unit_clip(cnf);
			base_p = unit_clip(con);
			have_base = 1; st = ST_UNKNOWN; ok = 1;
		end
		expected_words.insert(expected_words.size(),
			{pdev[12:0], cdev[12:0], vdev[15:0], st, oc, ok});
	endtask

	// tvalid stays high into the next word when no idle cycle follows
	task automatic send_word(logic [2:0] op, logic [79:0] d);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= d;
		predict_drift(op, d);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_cmd(logic [2:0] op, logic [31:0] t, logic [15:0] v, logic [15:0] c,
			logic [15:0] g);
		send_word(op, {g, c, v, t});
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_WINDOW: m_win  = val[15:0];
			REG_MINCNT: m_min  = val[6:0];
			REG_VLIM:   m_vlim = val[15:0];
			REG_CLIM:   m_clim = val[12:0];
			default:    m_plim = val[12:0];
		endcase
	endtask

	task automatic config_all(logic [31:0] w, logic [31:0] n, logic [31:0] vl,
			logic [31:0] cl, logic [31:0] pl);
		wait_drain();
		write_reg(REG_WINDOW, w);
		write_reg(REG_MINCNT, n);
		write_reg(REG_VLIM, vl);
		write_reg(REG_CLIM, cl);
		write_reg(REG_PLIM, pl);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic test_directed();
		int i;
		now_ms = 1000;
		send_cmd(OP_VALIDATE, now_ms, 0, 0, 0);          // no baseline
		send_cmd(OP_CAPTURE, now_ms, 0, 0, 0);           // too few samples
		send_cmd(3'd5, now_ms, 16'hffff, 0, 0);          // unused op
		send_cmd(3'd7, now_ms, 0, 0, 0);
		send_cmd(OP_LOAD, now_ms, 16'h8000, 16'h7fff, 16'h8000);
		send_cmd(OP_VALIDATE, now_ms, 0, 0, 0);          // too few after load
		for (i = 0; i < 6; i++) begin
			send_cmd(OP_LIMB, now_ms, i[0] ? 16'h8000 : 16'h7fff, i[1] ? 16'h8000 : 16'h7fff, 0);
			send_cmd(OP_CONF, now_ms, 0, 0, i[0] ? 16'hffff : 16'h1000);
			now_ms += 10;
		end
		send_cmd(OP_CAPTURE, now_ms, 0, 0, 0);
		send_cmd(OP_VALIDATE, now_ms, 0, 0, 0);
		send_cmd(OP_LOAD, now_ms, 16'h0005, 16'h0000, 16'h1000);
		send_cmd(OP_VALIDATE, now_ms, 0, 0, 0);
		send_cmd(OP_LOAD, now_ms, 16'h7fff, 16'h0800, 16'h0800);
		send_cmd(OP_VALIDATE, now_ms, 0, 0, 0);
		// sample from the future looks ancient and gets pruned
		send_cmd(OP_LIMB, now_ms + 32'd100000, 16'd100, 16'd100, 0);
		send_cmd(OP_VALIDATE, now_ms, 0, 0, 0);
	endtask

	task automatic random_burst(int n, int step_max);
		int i, k;
		logic [2:0] op;
		for (i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 38) op = OP_LIMB;
			else if (k < 76) op = OP_CONF;
			else if (k < 84) op = OP_VALIDATE;
			else if (k < 90) op = OP_CAPTURE;
			else if (k < 95) op = OP_LOAD;
			else op = 3'($urandom_range(7, 5));
			if ($urandom_range(49) == 0) now_ms = $urandom;
			else now_ms += $urandom_range(step_max);
			if ($urandom_range(3) == 0)
				send_cmd(op, now_ms, 16'($urandom), 16'($urandom), 16'($urandom));
			else
				send_cmd(op, now_ms, 16'($urandom_range(2000)), 16'($urandom_range(4200)),
					16'($urandom_range(4200)));
		end
	endtask

	task automatic test_random_phases();
		idle_pct = 0;  stall_pct = 0;  random_burst(100, 60);
		config_all(500, 5, 41, 41, 41);
		idle_pct = 84; stall_pct = 0;  random_burst(100, 40);
		config_all(65535, 64, 65535, 4096, 4096);
		idle_pct = 0;  stall_pct = 84; random_burst(100, 400);
		config_all(100, 2, 3, 8191, 0);   // below-minimum values, but for clim
		idle_pct = 20; stall_pct = 20; random_burst(60, 150);
		config_all(2000, 100, 2000, 600, 700);  // min_count above ring depth
		idle_pct = 0;  stall_pct = 0;  random_burst(40, 30);
	endtask

	always @(posedge clk) begin
		if (arst_n) m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %h", $time, m_axis_tdata);
				errors++;
			end else if (expected_words[0] !== m_axis_tdata) begin
				$display("%0t: mismatch expected ok=%0d oc=%0d st=%0d vd=%0d cd=%0d pd=%0d",
					$time, expected_words[0][0], expected_words[0][3:1],
					expected_words[0][5:4], expected_words[0][21:6],
					expected_words[0][34:22], expected_words[0][47:35]);
				$display("%0t:   actual   ok=%0d oc=%0d st=%0d vd=%0d cd=%0d pd=%0d",
					$time, m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[5:4],
					m_axis_tdata[21:6], m_axis_tdata[34:22], m_axis_tdata[47:35]);
				errors++;
				expected_words.delete(0);
			end else begin
				expected_words.delete(0);
			end
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| psel)
			wdog <= 0;
		else if (s_axis_tvalid || expected_words.size() != 0) begin
			wdog <= wdog + 1;
			if (wdog >= WDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		errors = 0; idle_pct = 0; stall_pct = 0; wdog = 0;
		m_win = 3000; m_min = 30; m_vlim = 1434; m_clim = 819; m_plim = 1024;
		lhead = 0; lcnt = 0; chead = 0; ccnt = 0;
		sum_v = 0; sum_c = 0; sum_p = 0; base_v = 0; base_c = 0; base_p = 0;
		have_base = 0; st = ST_MISSING;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		config_all(3000, 5, 1434, 819, 1024);
		test_directed();
		test_random_phases();
		wait_drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
